### src/mpd_pkg.sv
// Package with shared types and constants of the MQTT PUBLISH deframer.
package mpd_pkg;

  // Field and bus widths.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 28;
  localparam int unsigned TopicLenW = 16;
  localparam int unsigned CfgW      = 28;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned TdataW    = 40;
  localparam int unsigned TuserW    = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTopicLimit   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPayloadLimit = 1'd1;

  // Configuration reset values.
  localparam logic [TopicLenW-1:0] TopicLimitRst   = 16'd255;
  localparam logic [LenW-1:0]      PayloadLimitRst = 28'd1023;

  // Fixed header decoding.
  localparam logic [ByteW-1:0] TypeMask    = 8'hF0;
  localparam logic [ByteW-1:0] TypePublish = 8'h30;
  localparam logic [ByteW-1:0] LenDataMask = 8'h7F;
  localparam logic [ByteW-1:0] LenContMask = 8'h80;

  // Parser phase.
  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhBody
  } mpd_phase_e;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_payload;
    logic             has_data;
    logic             last;
    logic [LenW-1:0]  kept_count;
  } mpd_result_t;

endpackage

### src/mpd_parser.sv
// Byte-by-byte parser of the fixed header, length and PUBLISH body.
module mpd_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [mpd_pkg::ByteW-1:0]        rx_byte_i,
  input  logic [mpd_pkg::TopicLenW-1:0]    topic_limit_i,
  input  logic [mpd_pkg::LenW-1:0]         payload_limit_i,
  output logic                             res_valid_o,
  output mpd_pkg::mpd_result_t             res_o
);
  import mpd_pkg::*;

  mpd_phase_e           phase_q, phase_d;
  logic                 is_publish_q, is_publish_d;
  logic [LenW-1:0]      rem_len_q, rem_len_d;
  logic [1:0]           len_cnt_q, len_cnt_d;
  logic [LenW-1:0]      pos_q, pos_d;
  logic [TopicLenW-1:0] topic_len_q, topic_len_d;
  logic [LenW-1:0]      kept_q, kept_d;
  logic                 skip_q, skip_d;

  logic [LenW-1:0]      len_add;
  logic [LenW-1:0]      len_sum;
  logic                 len_done;
  logic [LenW:0]        pos_inc;
  logic                 final_byte;
  logic [LenW-1:0]      topic_off;
  logic [TopicLenW-1:0] topic_len_new;
  logic                 kept;
  logic                 payload;

  // Shift the seven length bits into their group.
  always_comb begin
    case (len_cnt_q)
      2'd0:    len_add = {21'd0, rx_byte_i[6:0]};
      2'd1:    len_add = {14'd0, rx_byte_i[6:0], 7'd0};
      2'd2:    len_add = {7'd0, rx_byte_i[6:0], 14'd0};
      default: len_add = {rx_byte_i[6:0], 21'd0};
    endcase
  end

  assign len_sum    = rem_len_q + len_add;
  assign len_done   = ((rx_byte_i & LenContMask) == '0) || (len_cnt_q == 2'd3);
  assign pos_inc    = {1'b0, pos_q} + {{LenW{1'b0}}, 1'b1};
  assign final_byte = (pos_inc == {1'b0, rem_len_q});
  assign topic_off  = pos_q - LenW'(2);
  assign topic_len_new = {topic_len_q[TopicLenW-1:ByteW], rx_byte_i};

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhHeader: phase_d = PhLength;
      PhLength: begin
        if (len_done) begin
          phase_d = (len_sum == '0) ? PhHeader : PhBody;
        end
      end
      PhBody: begin
        if (final_byte) begin
          phase_d = PhHeader;
        end
      end
      default: phase_d = PhHeader;
    endcase
  end

  // Counters, topic length and the result of this byte.
  always_comb begin
    is_publish_d = is_publish_q;
    rem_len_d    = rem_len_q;
    len_cnt_d    = len_cnt_q;
    pos_d        = pos_q;
    topic_len_d  = topic_len_q;
    kept_d       = kept_q;
    skip_d       = skip_q;
    kept         = 1'b0;
    payload      = 1'b0;
    res_valid_o  = 1'b0;
    case (phase_q)
      PhHeader: begin
        is_publish_d = ((rx_byte_i & TypeMask) == TypePublish);
        rem_len_d    = '0;
        len_cnt_d    = '0;
      end
      PhLength: begin
        rem_len_d = len_sum;
        len_cnt_d = len_cnt_q + 2'd1;
        if (len_done && (len_sum != '0)) begin
          pos_d       = '0;
          topic_len_d = '0;
          kept_d      = '0;
          skip_d      = !is_publish_q || (len_sum < LenW'(2));
        end
      end
      PhBody: begin
        if (!skip_q) begin
          if (pos_q == '0) begin
            topic_len_d = {rx_byte_i, 8'd0};
          end else if (pos_q == LenW'(1)) begin
            topic_len_d = topic_len_new;
            if (({13'd0, topic_len_new} + 29'd2) > {1'b0, rem_len_q}) begin
              skip_d = 1'b1;
            end
          end else if (topic_off < {12'd0, topic_len_q}) begin
            kept = (topic_off < {12'd0, topic_limit_i});
          end else begin
            payload = 1'b1;
            if (kept_q < payload_limit_i) begin
              kept   = 1'b1;
              kept_d = kept_q + LenW'(1);
            end
          end
        end
        pos_d       = pos_inc[LenW-1:0];
        res_valid_o = !skip_d && (kept || final_byte);
      end
      default: ;
    endcase
  end

  // Result fields; unused fields read as zero.
  always_comb begin
    res_o.data_byte  = kept ? rx_byte_i : '0;
    res_o.is_payload = kept && payload;
    res_o.has_data   = kept;
    res_o.last       = final_byte;
    res_o.kept_count = final_byte ? kept_d : '0;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      is_publish_q <= 1'b0;
      rem_len_q    <= '0;
      len_cnt_q    <= '0;
      pos_q        <= '0;
      topic_len_q  <= '0;
      kept_q       <= '0;
      skip_q       <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      is_publish_q <= is_publish_d;
      rem_len_q    <= rem_len_d;
      len_cnt_q    <= len_cnt_d;
      pos_q        <= pos_d;
      topic_len_q  <= topic_len_d;
      kept_q       <= kept_d;
      skip_q       <= skip_d;
    end
  end

endmodule

### src/mqtt_publish_deframer_unit.sv
// Top level of the MQTT PUBLISH deframer: config registers, parser and output buffer.
// A result is registered into the output register, or the skid register while stalled.
// Throughput: one received byte per cycle; the parser state updates in a single pass.
// A two-entry output (result register plus skid register) keeps input flowing through
// an output stall until the skid fills; input stops only while the skid register is full.
// Reset (rst_ni low, asynchronous) clears the parser state, empties the output and
// restores topic_limit to 255 and payload_limit to 1023.
module mqtt_publish_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [mpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mpd_pkg::CfgW-1:0]      cfg_wdata_i,
  // Received byte stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mpd_pkg::ByteW-1:0]     s_axis_tdata_i,  // [7:0] rx_byte
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mpd_pkg::TdataW-1:0]    m_axis_tdata_o,  // [7:0] data_byte, [35:8] kept_count
  output logic [mpd_pkg::TuserW-1:0]    m_axis_tuser_o,  // [0] is_payload, [1] has_data
  output logic                          m_axis_tlast_o   // last
);
  import mpd_pkg::*;

  logic [TopicLenW-1:0] topic_limit_q;
  logic [LenW-1:0]      payload_limit_q;
  logic                 in_xfer;
  logic                 res_valid;
  mpd_result_t          res;
  logic                 out_valid_q, skid_valid_q;
  mpd_result_t          out_q, skid_q;
  logic                 out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topic_limit_q   <= TopicLimitRst;
      payload_limit_q <= PayloadLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTopicLimit:   topic_limit_q   <= cfg_wdata_i[TopicLenW-1:0];
        RegPayloadLimit: payload_limit_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  mpd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_xfer),
    .rx_byte_i       (s_axis_tdata_i),
    .topic_limit_i   (topic_limit_q),
    .payload_limit_i (payload_limit_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_xfer && res_valid) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_free && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  // Pack the result onto the master side.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q.kept_count, out_q.data_byte};
  assign m_axis_tuser_o  = {out_q.has_data, out_q.is_payload};
  assign m_axis_tlast_o  = out_q.last;

endmodule

### src/mpd_checker.sv
// Port-level checks on the deframer's result stream, bound to the top level.
module mpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_valid_i,
  input logic                        m_ready_i,
  input logic [mpd_pkg::TdataW-1:0]  m_data_i,
  input logic [mpd_pkg::TuserW-1:0]  m_user_i,
  input logic                        m_last_i
);
  import mpd_pkg::*;

  // A stalled transfer keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i) && $stable(m_user_i)
      && $stable(m_last_i))
    else $error("result changed while stalled");

  // A result without a kept byte is only sent for the final body byte.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_user_i[1] |-> m_last_i)
    else $error("result with no data and no last");

  // Without a kept byte, the data byte and payload flag are zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_user_i[1] |-> (m_data_i[7:0] == 8'd0) && !m_user_i[0])
    else $error("data fields set without a kept byte");

  // The kept count is only carried by the last result; padding stays zero.
  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> (m_data_i[39:36] == 4'd0) && (m_last_i || (m_data_i[35:8] == 28'd0)))
    else $error("kept count outside last result");

endmodule

bind mqtt_publish_deframer_unit mpd_checker u_mpd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o),
  .m_user_i  (m_axis_tuser_o),
  .m_last_i  (m_axis_tlast_o)
);
